FILE: sv/adsr_envelope_generator_assert.svh
// Assertion macros for the envelope generator
`ifndef ADSR_ENVELOPE_GENERATOR_ASSERT_SVH
`define ADSR_ENVELOPE_GENERATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define AEG_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("aeg assertion failed");
`define AEG_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("aeg assertion failed");
`else
`define AEG_ASSERT_IMP(label, clk, rst_n, a, b)
`define AEG_ASSERT_NXT(label, clk, rst_n, a, b)
`endif

`endif

FILE: sv/aeg_pkg.sv
`timescale 1ns / 1ps
package aeg_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int LEVEL_FRAC_BITS = 16;

    localparam int LVL_W   = LEVEL_FRAC_BITS + 1;
    localparam int SUM_W   = LEVEL_FRAC_BITS + 2;
    localparam int FACT_W  = LEVEL_FRAC_BITS;
    localparam int HOLD_W  = 24;
    localparam int CFG_W   = 24;
    localparam int IDX_W   = 3;
    localparam int MA_W    = (SAMPLE_BITS > LVL_W) ? SAMPLE_BITS : LVL_W;
    localparam int MB_W    = SUM_W + 1;
    localparam int PROD_W  = MA_W + MB_W;
    localparam int RES_W   = PROD_W - LEVEL_FRAC_BITS;

    localparam logic [LVL_W-1:0] LVL_ONE = LVL_W'(1) << LEVEL_FRAC_BITS;

    localparam logic [LVL_W-1:0]  RST_ATTACK_STEP    = LVL_W'(655);
    localparam logic [FACT_W-1:0] RST_DECAY_FACTOR   = FACT_W'(65000);
    localparam logic [LVL_W-1:0]  RST_SUSTAIN_LEVEL  = LVL_W'(32768);
    localparam logic [FACT_W-1:0] RST_RELEASE_FACTOR = FACT_W'(65000);
    localparam logic [HOLD_W-1:0] RST_HOLD_SAMPLES   = HOLD_W'(0);

    typedef enum logic [IDX_W-1:0] {
        REG_ATTACK_STEP    = 3'd0,
        REG_DECAY_FACTOR   = 3'd1,
        REG_SUSTAIN_LEVEL  = 3'd2,
        REG_RELEASE_FACTOR = 3'd3,
        REG_HOLD_SAMPLES   = 3'd4
    } t_reg_idx;

    typedef enum logic [3:0] {
        CMD_IDLE,
        CMD_LOAD,
        CMD_ATTACK,
        CMD_DEC_MUL,
        CMD_DEC_UPD,
        CMD_HOLD,
        CMD_REL_MUL,
        CMD_REL_UPD,
        CMD_SCALE,
        CMD_OUT
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op op;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

FILE: sv/aeg_ctrl.sv
`timescale 1ns / 1ps
module aeg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  aeg_pkg::t_status i_status,
    output aeg_pkg::t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ATTACK,
        S_DEC_MUL,
        S_DEC_UPD,
        S_HOLD,
        S_REL_MUL,
        S_REL_UPD,
        S_SCALE,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state    <= S_ATTACK;
                        r_in_ready <= 1'b0;
                    end
                end
                S_ATTACK:  r_state <= S_DEC_MUL;
                S_DEC_MUL: r_state <= S_DEC_UPD;
                S_DEC_UPD: r_state <= S_HOLD;
                S_HOLD:    r_state <= S_REL_MUL;
                S_REL_MUL: r_state <= S_REL_UPD;
                S_REL_UPD: r_state <= S_SCALE;
                S_SCALE:   r_state <= S_OUT;
                S_OUT: begin
                    // hold until the output register can take the result
                    if (i_status.out_free) begin
                        r_state    <= S_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_in_ready <= 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        unique case (r_state)
            S_IDLE:    o_cmd.op = i_in_valid ? aeg_pkg::CMD_LOAD : aeg_pkg::CMD_IDLE;
            S_ATTACK:  o_cmd.op = aeg_pkg::CMD_ATTACK;
            S_DEC_MUL: o_cmd.op = aeg_pkg::CMD_DEC_MUL;
            S_DEC_UPD: o_cmd.op = aeg_pkg::CMD_DEC_UPD;
            S_HOLD:    o_cmd.op = aeg_pkg::CMD_HOLD;
            S_REL_MUL: o_cmd.op = aeg_pkg::CMD_REL_MUL;
            S_REL_UPD: o_cmd.op = aeg_pkg::CMD_REL_UPD;
            S_SCALE:   o_cmd.op = aeg_pkg::CMD_SCALE;
            S_OUT:     o_cmd.op = aeg_pkg::CMD_OUT;
            default:   o_cmd.op = aeg_pkg::CMD_IDLE;
        endcase
    end

    assign o_in_ready = r_in_ready;

endmodule

FILE: sv/aeg_datapath.sv
`timescale 1ns / 1ps
module aeg_datapath (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  aeg_pkg::t_cmd                              i_cmd,
    output aeg_pkg::t_status                           o_status,
    input  logic                                       i_cfg_we,
    input  logic [aeg_pkg::IDX_W-1:0]                  i_cfg_idx,
    input  logic [aeg_pkg::CFG_W-1:0]                  i_cfg_wdata,
    input  logic signed [aeg_pkg::SAMPLE_BITS-1:0]     i_sample_in,
    input  logic                                       i_gate,
    output logic                                       o_out_valid,
    input  logic                                       i_out_ready,
    output logic signed [aeg_pkg::SAMPLE_BITS-1:0]     o_sample_out
);

    localparam int F  = aeg_pkg::LEVEL_FRAC_BITS;
    localparam int SB = aeg_pkg::SAMPLE_BITS;

    // configuration
    logic [aeg_pkg::LVL_W-1:0]  r_attack_step;
    logic [aeg_pkg::FACT_W-1:0] r_decay_factor;
    logic [aeg_pkg::LVL_W-1:0]  r_sustain_level;
    logic [aeg_pkg::FACT_W-1:0] r_release_factor;
    logic [aeg_pkg::HOLD_W-1:0] r_hold_samples;

    // envelope state
    logic [aeg_pkg::LVL_W-1:0]  r_level, n_level;
    logic                       r_att, n_att;
    logic                       r_dec, n_dec;
    logic                       r_sus, n_sus;
    logic                       r_rel, n_rel;
    logic [aeg_pkg::HOLD_W-1:0] r_hold, n_hold;
    logic signed [SB-1:0]       r_held, n_held;

    // per-item working registers
    logic signed [SB-1:0]             r_sample;
    logic                             r_gate;
    logic [aeg_pkg::SUM_W-1:0]        r_out_lvl, n_out_lvl;
    logic                             r_wr, n_wr;
    logic signed [aeg_pkg::PROD_W-1:0] r_prod, n_prod;

    logic                 r_out_valid;
    logic signed [SB-1:0] r_sample_out;

    logic signed [aeg_pkg::MA_W-1:0]  w_ma;
    logic [aeg_pkg::SUM_W-1:0]        w_mb;
    logic [aeg_pkg::LVL_W-1:0]        w_mul_lvl;
    logic signed [aeg_pkg::RES_W-1:0] w_res;
    logic signed [SB-1:0]             w_sat;
    logic                             w_out_free;
    logic                             w_start;
    logic [aeg_pkg::SUM_W-1:0]        w_sum;
    logic [aeg_pkg::HOLD_W-1:0]       w_hold_inc;
    logic                             w_hold_run;

    assign w_out_free      = !r_out_valid || i_out_ready;
    assign o_status.out_free = w_out_free;

    // shared multiplier operand select
    always_comb begin
        case (i_cmd.op)
            aeg_pkg::CMD_DEC_MUL: begin
                w_ma = $signed(aeg_pkg::MA_W'({1'b0, r_decay_factor}));
                w_mb = aeg_pkg::SUM_W'(r_level);
            end
            aeg_pkg::CMD_REL_MUL: begin
                w_ma = $signed(aeg_pkg::MA_W'({1'b0, r_release_factor}));
                w_mb = aeg_pkg::SUM_W'(r_level);
            end
            default: begin
                w_ma = aeg_pkg::MA_W'(r_sample);
                w_mb = r_out_lvl;
            end
        endcase
    end

    assign w_mul_lvl = r_prod[F+aeg_pkg::LVL_W-1:F];
    assign w_res     = r_prod[aeg_pkg::PROD_W-1:F];

    // clamp the floored product to the signed sample range
    always_comb begin
        if ((&w_res[aeg_pkg::RES_W-1:SB-1]) || !(|w_res[aeg_pkg::RES_W-1:SB-1])) begin
            w_sat = w_res[SB-1:0];
        end else if (w_res[aeg_pkg::RES_W-1]) begin
            w_sat = {1'b1, {(SB-1){1'b0}}};
        end else begin
            w_sat = {1'b0, {(SB-1){1'b1}}};
        end
    end

    assign w_start    = r_gate && !r_att && !r_sus && !r_dec;
    assign w_hold_inc = r_hold + aeg_pkg::HOLD_W'(1);
    assign w_hold_run = (r_hold < r_hold_samples) && r_sus;

    always_comb begin
        n_level   = r_level;
        n_att     = r_att;
        n_dec     = r_dec;
        n_sus     = r_sus;
        n_rel     = r_rel;
        n_hold    = r_hold;
        n_held    = r_held;
        n_out_lvl = r_out_lvl;
        n_wr      = r_wr;
        n_prod    = r_prod;
        w_sum     = '0;
        case (i_cmd.op)
            aeg_pkg::CMD_LOAD: begin
                n_wr = 1'b0;
            end
            aeg_pkg::CMD_ATTACK: begin
                // gate restart, then one attack step on the updated flags
                if (w_start) begin
                    n_hold = '0;
                    n_dec  = 1'b0;
                    n_sus  = 1'b0;
                    n_rel  = 1'b0;
                    n_att  = 1'b1;
                end
                if (w_start || r_att) begin
                    w_sum     = aeg_pkg::SUM_W'(r_level) + aeg_pkg::SUM_W'(r_attack_step);
                    n_rel     = 1'b0;
                    n_out_lvl = w_sum;
                    n_wr      = 1'b1;
                    if (w_sum >= aeg_pkg::SUM_W'(aeg_pkg::LVL_ONE)) begin
                        n_level = aeg_pkg::LVL_ONE;
                        n_att   = 1'b0;
                        n_dec   = 1'b1;
                    end else begin
                        n_level = w_sum[aeg_pkg::LVL_W-1:0];
                    end
                end
            end
            aeg_pkg::CMD_DEC_MUL, aeg_pkg::CMD_REL_MUL, aeg_pkg::CMD_SCALE: begin
                n_prod = aeg_pkg::PROD_W'(w_ma) * aeg_pkg::PROD_W'($signed({1'b0, w_mb}));
            end
            aeg_pkg::CMD_DEC_UPD: begin
                if (r_dec) begin
                    n_level   = w_mul_lvl;
                    n_out_lvl = aeg_pkg::SUM_W'(w_mul_lvl);
                    n_wr      = 1'b1;
                    if (w_mul_lvl <= r_sustain_level) begin
                        n_dec = 1'b0;
                        n_sus = 1'b1;
                    end
                end
            end
            aeg_pkg::CMD_HOLD: begin
                if (w_hold_run) begin
                    n_hold    = w_hold_inc;
                    n_out_lvl = aeg_pkg::SUM_W'(r_level);
                    n_wr      = 1'b1;
                end
                if ((w_hold_run ? w_hold_inc : r_hold) >= r_hold_samples) begin
                    if (r_gate) begin
                        n_out_lvl = aeg_pkg::SUM_W'(r_level);
                        n_wr      = 1'b1;
                    end else begin
                        n_sus = 1'b0;
                        n_rel = 1'b1;
                    end
                end
            end
            aeg_pkg::CMD_REL_UPD: begin
                if (r_rel && (r_level != '0)) begin
                    n_level   = w_mul_lvl;
                    n_out_lvl = aeg_pkg::SUM_W'(w_mul_lvl);
                    n_wr      = 1'b1;
                end
            end
            aeg_pkg::CMD_OUT: begin
                if (w_out_free && r_wr) begin
                    n_held = w_sat;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack_step    <= aeg_pkg::RST_ATTACK_STEP;
            r_decay_factor   <= aeg_pkg::RST_DECAY_FACTOR;
            r_sustain_level  <= aeg_pkg::RST_SUSTAIN_LEVEL;
            r_release_factor <= aeg_pkg::RST_RELEASE_FACTOR;
            r_hold_samples   <= aeg_pkg::RST_HOLD_SAMPLES;
            r_level          <= '0;
            r_att            <= 1'b0;
            r_dec            <= 1'b0;
            r_sus            <= 1'b0;
            r_rel            <= 1'b0;
            r_hold           <= '0;
            r_held           <= '0;
            r_wr             <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    aeg_pkg::REG_ATTACK_STEP:
                        r_attack_step <= i_cfg_wdata[aeg_pkg::LVL_W-1:0];
                    aeg_pkg::REG_DECAY_FACTOR:
                        r_decay_factor <= i_cfg_wdata[aeg_pkg::FACT_W-1:0];
                    aeg_pkg::REG_SUSTAIN_LEVEL:
                        r_sustain_level <= i_cfg_wdata[aeg_pkg::LVL_W-1:0];
                    aeg_pkg::REG_RELEASE_FACTOR:
                        r_release_factor <= i_cfg_wdata[aeg_pkg::FACT_W-1:0];
                    aeg_pkg::REG_HOLD_SAMPLES:
                        r_hold_samples <= i_cfg_wdata[aeg_pkg::HOLD_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_level <= n_level;
            r_att   <= n_att;
            r_dec   <= n_dec;
            r_sus   <= n_sus;
            r_rel   <= n_rel;
            r_hold  <= n_hold;
            r_held  <= n_held;
            r_wr    <= n_wr;
            if ((i_cmd.op == aeg_pkg::CMD_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out_lvl <= n_out_lvl;
        r_prod    <= n_prod;
        if (i_cmd.op == aeg_pkg::CMD_LOAD) begin
            r_sample <= i_sample_in;
            r_gate   <= i_gate;
        end
        if ((i_cmd.op == aeg_pkg::CMD_OUT) && w_out_free) begin
            r_sample_out <= r_wr ? w_sat : r_held;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;

endmodule

FILE: sv/adsr_envelope_generator.sv
`timescale 1ns / 1ps
// ADSR envelope generator with exponential decay and release.
// Input channel: i_sample_in and i_gate, transferred when i_in_valid and
// o_in_ready are both high. Output channel: o_sample_out, transferred when
// o_out_valid and i_out_ready are both high.
// Configuration: i_cfg_we writes i_cfg_wdata to register i_cfg_idx
// (0 attack step, 1 decay factor, 2 sustain level, 3 release factor,
// 4 hold samples); other indexes are ignored. Write only while idle.
// One sample is in work at a time: the block takes no new sample until the
// last one has entered the output register. The controller runs a sequence
// of rule steps over one shared multiplier: attack, decay multiply and
// update, hold, release multiply and update, output scale and saturate.
// The output register parts the two channels: while the receiver stalls,
// the block still takes and works one new sample, then holds in its last
// step until the output register is free.
// Reset (synchronous, active low) loads register defaults, clears the
// envelope level, phase flags, hold count and held output, and empties
// the output register.
module adsr_envelope_generator (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic signed [aeg_pkg::SAMPLE_BITS-1:0] i_sample_in,
    input  logic                                   i_gate,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [aeg_pkg::SAMPLE_BITS-1:0] o_sample_out,
    input  logic                                   i_cfg_we,
    input  logic [aeg_pkg::IDX_W-1:0]              i_cfg_idx,
    input  logic [aeg_pkg::CFG_W-1:0]              i_cfg_wdata
);

`include "adsr_envelope_generator_assert.svh"

    aeg_pkg::t_cmd    w_cmd;
    aeg_pkg::t_status w_status;

    aeg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    aeg_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_sample_in  (i_sample_in),
        .i_gate       (i_gate),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out)
    );

    // busy after a transfer in
    `AEG_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    // the last step always lands in the output register
    `AEG_ASSERT_NXT(a_out_loaded, i_clk, i_rst_n, (w_cmd.op == aeg_pkg::CMD_OUT) && w_status.out_free, o_out_valid)
    // no rule step runs while the input side is open
    `AEG_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_in_ready, (w_cmd.op == aeg_pkg::CMD_IDLE) || (w_cmd.op == aeg_pkg::CMD_LOAD))

endmodule

FILE: sim/adsr_envelope_generator_test.sv
`timescale 1ns / 1ps
module adsr_envelope_generator_test;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 4;
    localparam int ITEM_TARGET   = 1900;
    localparam int LONG_HOLD     = 300;
    localparam int STALL_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 12;
    localparam int MAX_REPORTS   = 40;

    localparam int RX_OPEN   = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_SPARSE = 2;
    localparam int RX_SHUT   = 3;

    localparam int SB = aeg_pkg::SAMPLE_BITS;

    localparam logic [aeg_pkg::IDX_W-1:0] REG_UNMAPPED = aeg_pkg::IDX_W'(7);
    localparam logic [aeg_pkg::CFG_W-1:0] CFG_ALL_ONES = '1;
    localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};

    class envelope_checker;
        logic [aeg_pkg::LVL_W-1:0]  attack_step;
        logic [aeg_pkg::FACT_W-1:0] decay_factor;
        logic [aeg_pkg::LVL_W-1:0]  sustain_level;
        logic [aeg_pkg::FACT_W-1:0] release_factor;
        logic [aeg_pkg::HOLD_W-1:0] hold_samples;

        logic [aeg_pkg::LVL_W-1:0]  level;
        bit                         attack_on;
        bit                         decay_on;
        bit                         sustain_on;
        bit                         release_on;
        logic [aeg_pkg::HOLD_W-1:0] hold_count;
        logic signed [SB-1:0]       held_out;

        logic signed [SB-1:0] shaped_q[$];
        int errors;

        function new();
            attack_step    = aeg_pkg::RST_ATTACK_STEP;
            decay_factor   = aeg_pkg::RST_DECAY_FACTOR;
            sustain_level  = aeg_pkg::RST_SUSTAIN_LEVEL;
            release_factor = aeg_pkg::RST_RELEASE_FACTOR;
            hold_samples   = aeg_pkg::RST_HOLD_SAMPLES;
            level          = '0;
            attack_on      = 1'b0;
            decay_on       = 1'b0;
            sustain_on     = 1'b0;
            release_on     = 1'b0;
            hold_count     = '0;
            held_out       = '0;
            errors         = 0;
        endfunction

        function void set_reg(logic [aeg_pkg::IDX_W-1:0] idx,
                              logic [aeg_pkg::CFG_W-1:0] data);
            case (idx)
                aeg_pkg::REG_ATTACK_STEP:    attack_step    = data[aeg_pkg::LVL_W-1:0];
                aeg_pkg::REG_DECAY_FACTOR:   decay_factor   = data[aeg_pkg::FACT_W-1:0];
                aeg_pkg::REG_SUSTAIN_LEVEL:  sustain_level  = data[aeg_pkg::LVL_W-1:0];
                aeg_pkg::REG_RELEASE_FACTOR: release_factor = data[aeg_pkg::FACT_W-1:0];
                aeg_pkg::REG_HOLD_SAMPLES:   hold_samples   = data[aeg_pkg::HOLD_W-1:0];
                default: ;
            endcase
        endfunction

        // floor of sample times level, clamped to the sample range
        function logic signed [SB-1:0] scaled(logic signed [SB-1:0] s, longint lvl);
            longint r;
            r = (longint'(s) * lvl) >>> aeg_pkg::LEVEL_FRAC_BITS;
            if (r > SAMPLE_MAX) r = SAMPLE_MAX;
            if (r < SAMPLE_MIN) r = SAMPLE_MIN;
            return SB'(r);
        endfunction

        function logic [aeg_pkg::LVL_W-1:0] shrink(logic [aeg_pkg::FACT_W-1:0] factor);
            return aeg_pkg::LVL_W'((longint'(level) * longint'(factor))
                                   >> aeg_pkg::LEVEL_FRAC_BITS);
        endfunction

        function void take_sample(logic signed [SB-1:0] s, logic g);
            longint sum;
            if (g && !attack_on && !decay_on && !sustain_on) begin
                hold_count = '0;
                decay_on   = 1'b0;
                sustain_on = 1'b0;
                release_on = 1'b0;
                attack_on  = 1'b1;
            end
            if (attack_on) begin
                sum        = longint'(level) + longint'(attack_step);
                release_on = 1'b0;
                // output follows the sum before the clamp
                held_out   = scaled(s, sum);
                if (sum >= longint'(aeg_pkg::LVL_ONE)) begin
                    level     = aeg_pkg::LVL_ONE;
                    attack_on = 1'b0;
                    decay_on  = 1'b1;
                end else begin
                    level = aeg_pkg::LVL_W'(sum);
                end
            end
            if (decay_on) begin
                level    = shrink(decay_factor);
                held_out = scaled(s, longint'(level));
                if (level <= sustain_level) begin
                    decay_on   = 1'b0;
                    sustain_on = 1'b1;
                end
            end
            if (hold_count < hold_samples && sustain_on) begin
                held_out   = scaled(s, longint'(level));
                hold_count = hold_count + 1'b1;
            end
            if (hold_count >= hold_samples && g)
                held_out = scaled(s, longint'(level));
            if (hold_count >= hold_samples && !g) begin
                sustain_on = 1'b0;
                release_on = 1'b1;
            end
            if (release_on && level != '0) begin
                level    = shrink(release_factor);
                held_out = scaled(s, longint'(level));
            end
            shaped_q.push_back(held_out);
        endfunction

        task report_mismatch(string what);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s", $time, what);
        endtask

        task check_sample(logic signed [SB-1:0] got);
            logic signed [SB-1:0] want;
            if (shaped_q.size() == 0) begin
                report_mismatch($sformatf("sample_out %0d with none outstanding", got));
            end else begin
                want = shaped_q.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("sample_out %0d, predicted %0d", got, want));
            end
        endtask
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                           in_valid  = 1'b0;
    logic                           in_ready;
    logic signed [SB-1:0]           in_sample = '0;
    logic                           in_gate   = 1'b0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic signed [SB-1:0]           out_sample;
    logic                           cfg_we    = 1'b0;
    logic [aeg_pkg::IDX_W-1:0]      cfg_idx   = '0;
    logic [aeg_pkg::CFG_W-1:0]      cfg_wdata = '0;

    envelope_checker board;
    bit hold_off_req;
    bit note_gate;
    int note_left;
    int items_sent;
    int quiet_cycles;

    adsr_envelope_generator u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_sample_in  (in_sample),
        .i_gate       (in_gate),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_sample_out (out_sample),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            board.check_sample(out_sample);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver: segments of open, coin-flip, sparse and shut ready
    initial begin : rx_side
        int span;
        int mode;
        span = 0;
        mode = RX_OPEN;
        forever begin
            @(posedge clk);
            if (span == 0) begin
                if (hold_off_req) begin
                    hold_off_req = 1'b0;
                    mode = RX_SHUT;
                    span = LONG_HOLD;
                end else begin
                    mode = $urandom_range(RX_SHUT, RX_OPEN);
                    span = $urandom_range(40, 1);
                end
            end
            span--;
            case (mode)
                RX_OPEN:   out_ready <= 1'b1;
                RX_COIN:   out_ready <= 1'($urandom_range(1, 0));
                RX_SPARSE: out_ready <= ($urandom_range(3, 0) == 0);
                default:   out_ready <= 1'b0;
            endcase
        end
    end

    task automatic push_sample(input logic signed [SB-1:0] s, input logic g);
        in_valid  <= 1'b1;
        in_sample <= s;
        in_gate   <= g;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.take_sample(s, g);
        items_sent++;
    endtask

    task automatic pause_sender(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (board.shaped_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [aeg_pkg::IDX_W-1:0] idx,
                             input logic [aeg_pkg::CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        board.set_reg(idx, data);
    endtask

    task automatic program_envelope(input logic [aeg_pkg::CFG_W-1:0] atk,
                                    input logic [aeg_pkg::CFG_W-1:0] dec,
                                    input logic [aeg_pkg::CFG_W-1:0] sus,
                                    input logic [aeg_pkg::CFG_W-1:0] rel,
                                    input logic [aeg_pkg::CFG_W-1:0] hold);
        cfg_write(aeg_pkg::REG_ATTACK_STEP, atk);
        cfg_write(aeg_pkg::REG_DECAY_FACTOR, dec);
        cfg_write(aeg_pkg::REG_SUSTAIN_LEVEL, sus);
        cfg_write(aeg_pkg::REG_RELEASE_FACTOR, rel);
        cfg_write(aeg_pkg::REG_HOLD_SAMPLES, hold);
        cfg_write(REG_UNMAPPED, aeg_pkg::CFG_W'($urandom));
        cfg_we <= 1'b0;
    endtask

    function automatic logic [aeg_pkg::CFG_W-1:0] pick_step();
        case ($urandom_range(9, 0))
            0:       return '0;
            1:       return aeg_pkg::CFG_W'(aeg_pkg::LVL_ONE);
            2:       return CFG_ALL_ONES;
            3:       return aeg_pkg::CFG_W'($urandom);
            default: return aeg_pkg::CFG_W'($urandom_range(int'(aeg_pkg::LVL_ONE) - 1, 800));
        endcase
    endfunction

    function automatic logic [aeg_pkg::CFG_W-1:0] pick_factor();
        case ($urandom_range(9, 0))
            0:       return '0;
            1:       return aeg_pkg::CFG_W'(aeg_pkg::LVL_ONE - 1'b1);
            2:       return aeg_pkg::CFG_W'($urandom);
            default: return aeg_pkg::CFG_W'($urandom_range(int'(aeg_pkg::LVL_ONE) - 40,
                                                           int'(aeg_pkg::LVL_ONE) / 3));
        endcase
    endfunction

    function automatic logic [aeg_pkg::CFG_W-1:0] pick_sustain();
        case ($urandom_range(9, 0))
            0:       return '0;
            1:       return aeg_pkg::CFG_W'(aeg_pkg::LVL_ONE);
            2:       return CFG_ALL_ONES;
            default: return aeg_pkg::CFG_W'($urandom_range(int'(aeg_pkg::LVL_ONE) - 1, 0));
        endcase
    endfunction

    function automatic logic [aeg_pkg::CFG_W-1:0] pick_hold();
        case ($urandom_range(11, 0))
            0:       return '0;
            1:       return CFG_ALL_ONES;
            default: return aeg_pkg::CFG_W'($urandom_range(24, 0));
        endcase
    endfunction

    // mostly whole notes: gate held for a run, then released for a run
    task automatic pick_item(output logic signed [SB-1:0] s, output logic g);
        if (note_left == 0) begin
            note_gate = !note_gate;
            note_left = note_gate ? $urandom_range(60, 1) : $urandom_range(40, 1);
        end
        note_left--;
        g = ($urandom_range(7, 0) == 0) ? 1'($urandom_range(1, 0)) : note_gate;
        case ($urandom_range(11, 0))
            0:       s = SAMPLE_MAX;
            1:       s = SAMPLE_MIN;
            2:       s = '0;
            default: s = SB'($urandom);
        endcase
    endtask

    task automatic run_phase(input int count);
        logic signed [SB-1:0] s;
        logic g;
        int burst;
        while (count > 0) begin
            burst = $urandom_range(24, 1);
            while (burst > 0 && count > 0) begin
                pick_item(s, g);
                push_sample(s, g);
                burst--;
                count--;
            end
            if ($urandom_range(39, 0) == 0)
                wait_drained();
            else if ($urandom_range(2, 0) != 0)
                pause_sender($urandom_range(12, 1));
        end
        wait_drained();
    endtask

    initial begin
        board = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // release with no note sounding, register defaults in force
        push_sample(SAMPLE_MAX, 1'b0);
        push_sample(SAMPLE_MIN, 1'b0);
        wait_drained();

        // over-range values: the step overshoots 1.0 at once and decay ends at once
        program_envelope(CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES, '0);
        push_sample(SAMPLE_MAX, 1'b1);
        push_sample(SAMPLE_MIN, 1'b1);
        push_sample(SB'(-1), 1'b1);
        push_sample('0, 1'b1);
        push_sample(SAMPLE_MAX, 1'b0);
        push_sample(SAMPLE_MIN, 1'b0);
        wait_drained();

        // zero attack step: the level stays put
        program_envelope('0, aeg_pkg::CFG_W'(60000), aeg_pkg::CFG_W'(30000),
                         aeg_pkg::CFG_W'(40000), aeg_pkg::CFG_W'(2));
        push_sample(SB'(1000), 1'b1);
        push_sample(SAMPLE_MAX, 1'b1);
        push_sample(SAMPLE_MIN, 1'b0);
        push_sample(SAMPLE_MAX, 1'b0);
        wait_drained();

        // drop the gate part way through attack, then play a short note
        program_envelope(aeg_pkg::CFG_W'(20000), aeg_pkg::CFG_W'(50000),
                         aeg_pkg::CFG_W'(30000), aeg_pkg::CFG_W'(45000),
                         aeg_pkg::CFG_W'(3));
        push_sample(SAMPLE_MAX, 1'b1);
        repeat (3) push_sample(SB'($urandom), 1'b0);
        repeat (4) push_sample(SB'($urandom), 1'b1);
        repeat (3) push_sample(SB'($urandom), 1'b0);
        wait_drained();

        for (int phase = 0; items_sent < ITEM_TARGET; phase++) begin
            if (phase == 0)
                program_envelope(aeg_pkg::CFG_W'(aeg_pkg::LVL_ONE), pick_factor(),
                                 pick_sustain(), pick_factor(), CFG_ALL_ONES);
            else
                program_envelope(pick_step(), pick_factor(), pick_sustain(), pick_factor(),
                                 pick_hold());
            // shut the output for a long stretch so the input backs up
            if (phase == 1)
                hold_off_req = 1'b1;
            run_phase($urandom_range(220, 80));
        end

        if (board.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+sv
sv/aeg_pkg.sv
sv/aeg_ctrl.sv
sv/aeg_datapath.sv
sv/adsr_envelope_generator.sv
sim/adsr_envelope_generator_test.sv
